// File: sv/rth_pkg.sv
// ============================================================================
// rth_pkg: shared types and constants of the RGB to HSV converter
// Holds the hue format, the sector bases and the per-item control word that
// travels down the division chain.
// ============================================================================
package rth_pkg;

    // Default width of one color component.
    localparam int COMPONENT_BITS_DEF = 8;

    // Hue is an unsigned fraction of a full turn in units of 1/65536.
    localparam int HUE_BITS   = 16;
    // The hue offset inside a sector never exceeds 65536/6, so 14 bits hold it.
    localparam int HUE_Q_BITS = 14;

    localparam logic [HUE_BITS-1:0] HUE_BASE_RED   = 16'd0;
    localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = 16'd21845;
    localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE  = 16'd43691;

    // Which component holds the maximum; red wins ties, then green.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Control word of one item in flight.
    typedef struct packed {
        logic    valid;
        sector_t sector;
        logic    hue_neg;
        logic    hue_zero;
        logic    undef;
    } item_ctrl_t;

endpackage

// File: sv/rth_pixel_if.sv
// ============================================================================
// rth_pixel_if: input channel of the RGB to HSV converter
// Carries one RGB pixel per item with a valid/ready handshake.
// ============================================================================
interface rth_pixel_if #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: sv/rth_hsv_if.sv
// ============================================================================
// rth_hsv_if: output channel of the RGB to HSV converter
// Carries one HSV result per item with a valid/ready handshake.
// ============================================================================
interface rth_hsv_if #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [rth_pkg::HUE_BITS-1:0] hue;
    logic [COMPONENT_BITS-1:0]    saturation;
    logic [COMPONENT_BITS-1:0]    brightness;
    logic                         hue_undefined;

    modport source (output valid, output hue, output saturation, output brightness,
                    output hue_undefined, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input hue_undefined, output ready);
endinterface

// File: sv/rgb_to_hsv_converter.sv
// Path: each accepted pixel passes the entry register, STEPS division cells and the
// output register; STEPS is the larger of COMPONENT_BITS and 14.
// Throughput: one pixel per cycle unless hsv stalls; one quotient bit per cell.
// Reset: rst_n clears every valid flag asynchronously; data registers are not reset.
// ============================================================================
// rgb_to_hsv_converter: pipelined RGB to HSV pixel converter
// An entry stage finds max, min and sector, a chain of division cells forms
// saturation and hue offset one bit per cell, and an output stage builds hue.
// ============================================================================
module rgb_to_hsv_converter #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rth_pixel_if.sink  pixel,
    rth_hsv_if.source  hsv
);
    localparam int W      = COMPONENT_BITS;
    localparam int STEPS  = (W > rth_pkg::HUE_Q_BITS) ? W : rth_pkg::HUE_Q_BITS;
    localparam int SAT_RW = W + STEPS;
    localparam int HUE_RW = W + STEPS + 3;

    // Links between the stages; index i feeds cell i, index STEPS feeds the output.
    rth_pkg::item_ctrl_t ctrl    [0:STEPS];
    logic                rdy     [0:STEPS];
    logic [SAT_RW-1:0]   sat_rem [0:STEPS];
    logic [SAT_RW-1:0]   sat_div [0:STEPS];
    logic [STEPS-1:0]    sat_q   [0:STEPS];
    logic [HUE_RW-1:0]   hue_rem [0:STEPS];
    logic [HUE_RW-1:0]   hue_div [0:STEPS];
    logic [STEPS-1:0]    hue_q   [0:STEPS];
    logic [W-1:0]        bright  [0:STEPS];

    rth_front #(
        .COMPONENT_BITS (W),
        .STEPS          (STEPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .out_ctrl    (ctrl[0]),
        .out_ready   (rdy[0]),
        .out_sat_rem (sat_rem[0]),
        .out_sat_div (sat_div[0]),
        .out_hue_rem (hue_rem[0]),
        .out_hue_div (hue_div[0]),
        .out_bright  (bright[0])
    );

    // Quotients start empty.
    assign sat_q[0] = '0;
    assign hue_q[0] = '0;

    // Division chain, most significant quotient bit first.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rth_div_cell #(
            .COMPONENT_BITS (W),
            .STEPS          (STEPS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_ctrl     (ctrl[i]),
            .in_ready    (rdy[i]),
            .in_sat_rem  (sat_rem[i]),
            .in_sat_div  (sat_div[i]),
            .in_sat_q    (sat_q[i]),
            .in_hue_rem  (hue_rem[i]),
            .in_hue_div  (hue_div[i]),
            .in_hue_q    (hue_q[i]),
            .in_bright   (bright[i]),
            .out_ctrl    (ctrl[i+1]),
            .out_ready   (rdy[i+1]),
            .out_sat_rem (sat_rem[i+1]),
            .out_sat_div (sat_div[i+1]),
            .out_sat_q   (sat_q[i+1]),
            .out_hue_rem (hue_rem[i+1]),
            .out_hue_div (hue_div[i+1]),
            .out_hue_q   (hue_q[i+1]),
            .out_bright  (bright[i+1])
        );
    end

    rth_back #(
        .COMPONENT_BITS (W),
        .STEPS          (STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (ctrl[STEPS]),
        .in_ready  (rdy[STEPS]),
        .in_sat_q  (sat_q[STEPS]),
        .in_hue_q  (hue_q[STEPS]),
        .in_bright (bright[STEPS]),
        .hsv       (hsv)
    );

`ifndef SYNTHESIS
    // A black result carries zero hue, saturation and brightness.
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && hsv.hue_undefined |->
            hsv.hue == '0 && hsv.saturation == '0 && hsv.brightness == '0)
        else $error("black item with nonzero fields");

    // A result with defined hue has a nonzero brightness.
    a_defined_bright: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && !hsv.hue_undefined |-> hsv.brightness != '0)
        else $error("defined hue with zero brightness");

    // The input is refused only when the whole chain backs up from a stalled output.
    a_refuse_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> hsv.valid && !hsv.ready)
        else $error("input refused while output not stalled");
`endif

endmodule

// File: sv/rth_front.sv
// ============================================================================
// rth_front: entry stage of the RGB to HSV converter
// Finds maximum, minimum and sector of a pixel and registers the dividends
// and pre-aligned divisors for the saturation and hue divisions.
// ============================================================================
module rth_front #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF,
    parameter int STEPS          = rth_pkg::HUE_Q_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rth_pixel_if.sink                  pixel,
    output rth_pkg::item_ctrl_t        out_ctrl,
    input  logic                       out_ready,
    output logic [COMPONENT_BITS+STEPS-1:0]   out_sat_rem,
    output logic [COMPONENT_BITS+STEPS-1:0]   out_sat_div,
    output logic [COMPONENT_BITS+STEPS+2:0]   out_hue_rem,
    output logic [COMPONENT_BITS+STEPS+2:0]   out_hue_div,
    output logic [COMPONENT_BITS-1:0]         out_bright
);
    localparam int W      = COMPONENT_BITS;
    localparam int SAT_RW = W + STEPS;
    localparam int HUE_RW = W + STEPS + 3;
    localparam int HUE_B  = rth_pkg::HUE_BITS;

    logic [W-1:0]   mx;
    logic [W-1:0]   mn;
    logic [W-1:0]   delta;
    logic [W-1:0]   mag;
    logic           neg;
    logic [W+2:0]   six_delta;
    logic [2*W-1:0] sat_prod;
    logic           ready;

    rth_pkg::sector_t    sector;
    rth_pkg::item_ctrl_t ctrl_next;
    rth_pkg::item_ctrl_t ctrl_reg;

    logic [SAT_RW-1:0] sat_rem_reg;
    logic [SAT_RW-1:0] sat_div_reg;
    logic [HUE_RW-1:0] hue_rem_reg;
    logic [HUE_RW-1:0] hue_div_reg;
    logic [W-1:0]      bright_reg;

    // Maximum, minimum and the sector; red is tested first, then green.
    always_comb
    begin
        mx = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue > mx) mx = pixel.blue;
        mn = pixel.red;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue < mn) mn = pixel.blue;
        delta = mx - mn;

        if (pixel.red == mx)
            sector = rth_pkg::SECT_RED;
        else if (pixel.green == mx)
            sector = rth_pkg::SECT_GREEN;
        else
            sector = rth_pkg::SECT_BLUE;
    end

    // Sign and magnitude of the component difference inside the sector.
    always_comb
    begin
        case (sector)
            rth_pkg::SECT_RED:
            begin
                neg = pixel.green < pixel.blue;
                mag = neg ? pixel.blue - pixel.green : pixel.green - pixel.blue;
            end
            rth_pkg::SECT_GREEN:
            begin
                neg = pixel.blue < pixel.red;
                mag = neg ? pixel.red - pixel.blue : pixel.blue - pixel.red;
            end
            rth_pkg::SECT_BLUE:
            begin
                neg = pixel.red < pixel.green;
                mag = neg ? pixel.green - pixel.red : pixel.red - pixel.green;
            end
            default:
            begin
                neg = 1'b0;
                mag = '0;
            end
        endcase
    end

    // Dividend delta*(2^W-1) and divisor 6*delta without multipliers.
    assign sat_prod  = {delta, {W{1'b0}}} - {{W{1'b0}}, delta};
    assign six_delta = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

    always_comb
    begin
        ctrl_next.valid    = pixel.valid;
        ctrl_next.sector   = sector;
        ctrl_next.hue_neg  = neg;
        ctrl_next.hue_zero = (delta == '0);
        ctrl_next.undef    = (mx == '0);
    end

    assign ready       = !ctrl_reg.valid || out_ready;
    assign pixel.ready = ready;

    // Control register of the entry stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (ready)
            ctrl_reg <= ctrl_next;
    end

    // Payload of the entry stage; divisors are aligned to the first quotient bit.
    always_ff @(posedge clk)
    begin
        if (ready && pixel.valid)
        begin
            sat_rem_reg <= SAT_RW'(sat_prod);
            sat_div_reg <= SAT_RW'({mx, {(STEPS-1){1'b0}}});
            hue_rem_reg <= HUE_RW'({mag, {HUE_B{1'b0}}});
            hue_div_reg <= HUE_RW'({six_delta, {(STEPS-1){1'b0}}});
            bright_reg  <= mx;
        end
    end

    assign out_ctrl    = ctrl_reg;
    assign out_sat_rem = sat_rem_reg;
    assign out_sat_div = sat_div_reg;
    assign out_hue_rem = hue_rem_reg;
    assign out_hue_div = hue_div_reg;
    assign out_bright  = bright_reg;

endmodule

// File: sv/rth_div_cell.sv
// ============================================================================
// rth_div_cell: one cell of the division chain
// Produces one quotient bit of the saturation division and one of the hue
// division by restoring compare and subtract, then hands the item on.
// ============================================================================
module rth_div_cell #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF,
    parameter int STEPS          = rth_pkg::HUE_Q_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rth_pkg::item_ctrl_t               in_ctrl,
    output logic                              in_ready,
    input  logic [COMPONENT_BITS+STEPS-1:0]   in_sat_rem,
    input  logic [COMPONENT_BITS+STEPS-1:0]   in_sat_div,
    input  logic [STEPS-1:0]                  in_sat_q,
    input  logic [COMPONENT_BITS+STEPS+2:0]   in_hue_rem,
    input  logic [COMPONENT_BITS+STEPS+2:0]   in_hue_div,
    input  logic [STEPS-1:0]                  in_hue_q,
    input  logic [COMPONENT_BITS-1:0]         in_bright,
    output rth_pkg::item_ctrl_t               out_ctrl,
    input  logic                              out_ready,
    output logic [COMPONENT_BITS+STEPS-1:0]   out_sat_rem,
    output logic [COMPONENT_BITS+STEPS-1:0]   out_sat_div,
    output logic [STEPS-1:0]                  out_sat_q,
    output logic [COMPONENT_BITS+STEPS+2:0]   out_hue_rem,
    output logic [COMPONENT_BITS+STEPS+2:0]   out_hue_div,
    output logic [STEPS-1:0]                  out_hue_q,
    output logic [COMPONENT_BITS-1:0]         out_bright
);
    localparam int W      = COMPONENT_BITS;
    localparam int SAT_RW = W + STEPS;
    localparam int HUE_RW = W + STEPS + 3;

    logic              ready;
    logic              sat_ge;
    logic              hue_ge;

    rth_pkg::item_ctrl_t ctrl_reg;

    logic [SAT_RW-1:0] sat_rem_next;
    logic [HUE_RW-1:0] hue_rem_next;
    logic [SAT_RW-1:0] sat_rem_reg;
    logic [SAT_RW-1:0] sat_div_reg;
    logic [STEPS-1:0]  sat_q_reg;
    logic [HUE_RW-1:0] hue_rem_reg;
    logic [HUE_RW-1:0] hue_div_reg;
    logic [STEPS-1:0]  hue_q_reg;
    logic [W-1:0]      bright_reg;

    // One restoring step of each division.
    assign sat_ge       = in_sat_rem >= in_sat_div;
    assign sat_rem_next = sat_ge ? in_sat_rem - in_sat_div : in_sat_rem;
    assign hue_ge       = in_hue_rem >= in_hue_div;
    assign hue_rem_next = hue_ge ? in_hue_rem - in_hue_div : in_hue_rem;

    assign ready    = !ctrl_reg.valid || out_ready;
    assign in_ready = ready;

    // Control register; an empty cell or a moving chain takes the next item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (ready)
            ctrl_reg <= in_ctrl;
    end

    // Partial remainders, shifted divisors and growing quotients.
    always_ff @(posedge clk)
    begin
        if (ready && in_ctrl.valid)
        begin
            sat_rem_reg <= sat_rem_next;
            sat_div_reg <= in_sat_div >> 1;
            sat_q_reg   <= {in_sat_q[STEPS-2:0], sat_ge};
            hue_rem_reg <= hue_rem_next;
            hue_div_reg <= in_hue_div >> 1;
            hue_q_reg   <= {in_hue_q[STEPS-2:0], hue_ge};
            bright_reg  <= in_bright;
        end
    end

    assign out_ctrl    = ctrl_reg;
    assign out_sat_rem = sat_rem_reg;
    assign out_sat_div = sat_div_reg;
    assign out_sat_q   = sat_q_reg;
    assign out_hue_rem = hue_rem_reg;
    assign out_hue_div = hue_div_reg;
    assign out_hue_q   = hue_q_reg;
    assign out_bright  = bright_reg;

endmodule

// File: sv/rth_back.sv
// ============================================================================
// rth_back: output stage of the RGB to HSV converter
// Adds the signed sector offset to the sector base, applies the black and
// gray cases and holds the result item until it is taken.
// ============================================================================
module rth_back #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF,
    parameter int STEPS          = rth_pkg::HUE_Q_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rth_pkg::item_ctrl_t         in_ctrl,
    output logic                        in_ready,
    input  logic [STEPS-1:0]            in_sat_q,
    input  logic [STEPS-1:0]            in_hue_q,
    input  logic [COMPONENT_BITS-1:0]   in_bright,
    rth_hsv_if.source                   hsv
);
    localparam int W     = COMPONENT_BITS;
    localparam int HUE_B = rth_pkg::HUE_BITS;

    logic             ready;
    logic [HUE_B-1:0] q_ext;
    logic [HUE_B-1:0] offset;
    logic [HUE_B-1:0] base;
    logic [HUE_B-1:0] hue_next;
    logic [W-1:0]     sat_next;

    logic             valid_reg;
    logic [HUE_B-1:0] hue_reg;
    logic [W-1:0]     sat_reg;
    logic [W-1:0]     bright_reg;
    logic             undef_reg;

    // Sector base plus the signed offset, wrapping modulo a full turn.
    always_comb
    begin
        case (in_ctrl.sector)
            rth_pkg::SECT_RED:   base = rth_pkg::HUE_BASE_RED;
            rth_pkg::SECT_GREEN: base = rth_pkg::HUE_BASE_GREEN;
            rth_pkg::SECT_BLUE:  base = rth_pkg::HUE_BASE_BLUE;
            default:             base = '0;
        endcase
    end

    assign q_ext    = HUE_B'(in_hue_q);
    assign offset   = in_ctrl.hue_neg ? (~q_ext + 1'b1) : q_ext;
    assign hue_next = in_ctrl.hue_zero ? '0 : base + offset;
    assign sat_next = in_ctrl.undef ? '0 : W'(in_sat_q);

    assign ready    = !valid_reg || hsv.ready;
    assign in_ready = ready;

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= in_ctrl.valid;
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ready && in_ctrl.valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= in_bright;
            undef_reg  <= in_ctrl.undef;
        end
    end

    assign hsv.valid         = valid_reg;
    assign hsv.hue           = hue_reg;
    assign hsv.saturation    = sat_reg;
    assign hsv.brightness    = bright_reg;
    assign hsv.hue_undefined = undef_reg;

endmodule
